// File: sv/tmcrg_pkg.sv
package tmcrg_pkg;

    localparam int VIDEO_DEPTH = 1024;
    localparam int GLYPH_DEPTH = 2048;
    localparam int VIDEO_AW    = $clog2(VIDEO_DEPTH);
    localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);

    localparam int ADDR_W  = 11;
    localparam int DATA_W  = 8;
    localparam int COLOR_W = 4;
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int OP_W    = 2;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 8;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [X_W-1:0]     X_LAST      = '1;
    localparam logic [Y_W-1:0]     Y_LAST      = '1;
    localparam logic [COLOR_W-1:0] COLOR_BASE  = 4'd2;
    localparam logic [COLOR_W-1:0] COLOR_MAX   = 4'd9;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_WR_VIDEO = 2'd1,
        OP_WR_COLOR = 2'd2,
        OP_WR_GLYPH = 2'd3
    } op_t;

    localparam logic [CIDX_W-1:0] REG_WIDE_MODE    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_COLOR_ENABLE = 2'd1;

endpackage

// File: sv/text_mode_char_raster_gen_unit.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid / s_tready  tuser op, tdata wr_addr, wr_data
// m_        out  m_tvalid / m_tready  tdata color, x, y; tlast frame end
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data (bit 0 kept)
//
// One item per cycle while the output is not stalled; a tick's pixel passes
// through video/color RAM read, glyph ROM read and the output register.
// Writes produce no output and finish in the cycle they are taken.
// aresetn (sync, active low) clears raster position and valid bits and resets
// the config registers (wide mode on, color off); the RAMs hold no reset value.
// The pipeline moves only when the output register is free or drained,
// so s_tready drops exactly while a pixel waits on m_tready.
module text_mode_char_raster_gen_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [10:0] wr_addr, [18:11] wr_data, [23:19] zero
    input  logic [tmcrg_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [tmcrg_pkg::OP_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] pixel_color, [12:4] pixel_x, [20:13] pixel_y, [23:21] zero
    output logic [tmcrg_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmcrg_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [tmcrg_pkg::CDATA_W-1:0]    cfg_data
);
    import tmcrg_pkg::*;

    logic [DATA_W-1:0]  video_mem [VIDEO_DEPTH];
    logic [COLOR_W-1:0] color_mem [VIDEO_DEPTH];
    logic [DATA_W-1:0]  glyph_rom [GLYPH_DEPTH];

    logic wide_mode_reg, color_enable_reg;

    logic [X_W-1:0] raster_x_reg, raster_x_next;
    logic [Y_W-1:0] raster_y_reg, raster_y_next;

    logic               s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic [DATA_W-1:0]  s1_code_reg;
    logic [COLOR_W-1:0] s1_color_reg, s2_color_reg;
    logic [2:0]         s1_line_reg;
    logic [2:0]         s1_bit_reg, s2_bit_reg;
    logic [X_W-1:0]     s1_x_reg, s2_x_reg, m_x_reg;
    logic [Y_W-1:0]     s1_y_reg, s2_y_reg, m_y_reg;
    logic [DATA_W-1:0]  s2_glyph_reg;
    logic [COLOR_W-1:0] m_color_reg, m_color_next;
    logic               m_last_reg;

    op_t                op;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic               adv, accept, tick;
    logic [VIDEO_AW-1:0] cell_addr;
    logic [2:0]          line, bitpos;
    logic                gbit;

    assign op      = op_t'(s_tuser);
    assign wr_addr = s_tdata[ADDR_W-1:0];
    assign wr_data = s_tdata[ADDR_W +: DATA_W];

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;
    assign tick     = accept && (op == OP_TICK);
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_mode_reg    <= 1'b1;
            color_enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_WIDE_MODE) begin
                wide_mode_reg <= cfg_data[0];
            end else if (cfg_index == REG_COLOR_ENABLE) begin
                color_enable_reg <= cfg_data[0];
            end
        end
    end

    always_comb begin
        if (wide_mode_reg) begin
            cell_addr = {raster_y_reg[7:4], raster_x_reg[8:3]};
            line      = raster_y_reg[3:1];
            bitpos    = raster_x_reg[2:0];
        end else begin
            cell_addr = {raster_y_reg[7:3], raster_x_reg[8:4]};
            line      = raster_y_reg[2:0];
            bitpos    = raster_x_reg[3:1];
        end
    end

    always_comb begin
        if (raster_x_reg == X_LAST) begin
            raster_x_next = '0;
            raster_y_next = raster_y_reg + 1'b1;
        end else begin
            raster_x_next = raster_x_reg + 1'b1;
            raster_y_next = raster_y_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raster_x_reg <= '0;
            raster_y_reg <= '0;
        end else if (tick) begin
            raster_x_reg <= raster_x_next;
            raster_y_reg <= raster_y_next;
        end
    end

    // RAMs: write on accept, read for the tick taken in the same cycle
    always_ff @(posedge aclk) begin
        if (accept && op == OP_WR_VIDEO && !wr_addr[ADDR_W-1]) begin
            video_mem[wr_addr[VIDEO_AW-1:0]] <= wr_data;
        end
        if (adv) begin
            s1_code_reg <= video_mem[cell_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && op == OP_WR_COLOR && !wr_addr[ADDR_W-1]) begin
            color_mem[wr_addr[VIDEO_AW-1:0]] <= wr_data[COLOR_W-1:0];
        end
        if (adv) begin
            s1_color_reg <= color_mem[cell_addr];
        end
    end

    // read-before-write keeps a later glyph write out of an earlier tick
    always_ff @(posedge aclk) begin
        if (accept && op == OP_WR_GLYPH) begin
            glyph_rom[wr_addr[GLYPH_AW-1:0]] <= wr_data;
        end
        if (adv) begin
            s2_glyph_reg <= glyph_rom[{s1_code_reg, s1_line_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_line_reg  <= line;
            s1_bit_reg   <= bitpos;
            s1_x_reg     <= raster_x_reg;
            s1_y_reg     <= raster_y_reg;
            s2_color_reg <= s1_color_reg;
            s2_bit_reg   <= s1_bit_reg;
            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            m_color_reg  <= m_color_next;
            m_x_reg      <= s2_x_reg;
            m_y_reg      <= s2_y_reg;
            m_last_reg   <= (s2_x_reg == X_LAST) && (s2_y_reg == Y_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= tick;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    assign gbit = s2_glyph_reg[~s2_bit_reg];

    always_comb begin
        if (!color_enable_reg) begin
            m_color_next = {{(COLOR_W-1){1'b0}}, gbit};
        end else if (gbit ^ s2_color_reg[0]) begin
            m_color_next = {1'b0, s2_color_reg[COLOR_W-1:1]} + COLOR_BASE;
        end else begin
            m_color_next = '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W-COLOR_W-X_W-Y_W){1'b0}}, m_y_reg, m_x_reg, m_color_reg};

endmodule

// File: sv/tmcrg_checker.sv
module tmcrg_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tmcrg_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                             m_tlast
);
    import tmcrg_pkg::*;

    logic [COLOR_W-1:0] color;
    logic [X_W-1:0]     px;
    logic [Y_W-1:0]     py;

    assign color = m_tdata[COLOR_W-1:0];
    assign px    = m_tdata[COLOR_W +: X_W];
    assign py    = m_tdata[COLOR_W+X_W +: Y_W];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output backpressure");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (px == X_LAST && py == Y_LAST)))
        else $error("frame end flag does not match pixel position");

    a_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> color <= COLOR_MAX)
        else $error("palette index out of range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind text_mode_char_raster_gen_unit tmcrg_checker u_tmcrg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tmcrg_pkg::*;

    localparam logic [CIDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CIDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int IDLE_PCT     = 28;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTS   = 25;
    localparam int FILL_CELLS   = 64;
    localparam int FILL_LINES   = 2;
    localparam int GLYPH_CODES  = 256;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic               last;
    } pixel_t;

    class raster_scoreboard;
        logic [DATA_W-1:0]  video_ram [VIDEO_DEPTH];
        logic [COLOR_W-1:0] color_ram [VIDEO_DEPTH];
        logic [DATA_W-1:0]  glyph_rom [GLYPH_DEPTH];
        logic [X_W-1:0]     pos_x;
        logic [Y_W-1:0]     pos_y;
        logic               wide_mode;
        logic               color_on;
        pixel_t             pending_pixels[$];
        int                 errors;
        int                 items_taken;
        int                 pixels_checked;

        function new();
            pos_x = '0;
            pos_y = '0;
            wide_mode = 1'b1;
            color_on = 1'b0;
            errors = 0;
            items_taken = 0;
            pixels_checked = 0;
        endfunction

        function void note_config(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
            if (idx == REG_WIDE_MODE) begin
                wide_mode = val[0];
            end else if (idx == REG_COLOR_ENABLE) begin
                color_on = val[0];
            end
        endfunction

        function logic [VIDEO_AW-1:0] cell_now();
            return wide_mode ? {pos_y[7:4], pos_x[8:3]} : {pos_y[7:3], pos_x[8:4]};
        endfunction

        function logic [GLYPH_AW-1:0] glyph_now();
            logic [2:0] line;
            line = wide_mode ? pos_y[3:1] : pos_y[2:0];
            return {video_ram[cell_now()], line};
        endfunction

        function pixel_t shade();
            pixel_t             p;
            logic [2:0]         bitpos;
            logic               g;
            logic [COLOR_W-1:0] cv;
            bitpos = wide_mode ? pos_x[2:0] : pos_x[3:1];
            g = glyph_rom[glyph_now()][3'd7 - bitpos];
            cv = color_ram[cell_now()];
            if (!color_on) begin
                p.color = {3'b000, g};
            end else if (g ^ cv[0]) begin
                p.color = COLOR_BASE + {1'b0, cv[3:1]};
            end else begin
                p.color = '0;
            end
            p.x = pos_x;
            p.y = pos_y;
            p.last = (pos_x == X_LAST) && (pos_y == Y_LAST);
            return p;
        endfunction

        function void note_input(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            pixel_t p;
            items_taken++;
            case (op)
                OP_WR_VIDEO: begin
                    if (addr < VIDEO_DEPTH) video_ram[addr[VIDEO_AW-1:0]] = data;
                end
                OP_WR_COLOR: begin
                    if (addr < VIDEO_DEPTH) color_ram[addr[VIDEO_AW-1:0]] = data[COLOR_W-1:0];
                end
                OP_WR_GLYPH: begin
                    glyph_rom[addr] = data;
                end
                default: begin
                    p = shade();
                    pending_pixels.push_back(p);
                    if (pos_x == X_LAST) begin
                        pos_x = '0;
                        pos_y = pos_y + 1'b1;
                    end else begin
                        pos_x = pos_x + 1'b1;
                    end
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
        endtask

        task check_pixel(logic [M_TDATA_W-1:0] data, logic last);
            pixel_t             want;
            logic [COLOR_W-1:0] got_color;
            logic [X_W-1:0]     got_x;
            logic [Y_W-1:0]     got_y;
            got_color = data[COLOR_W-1:0];
            got_x = data[COLOR_W +: X_W];
            got_y = data[COLOR_W+X_W +: Y_W];
            if (pending_pixels.size() == 0) begin
                report($sformatf("pixel (%0d,%0d) with none expected", got_x, got_y));
                return;
            end
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got_color !== want.color)
                report($sformatf("color at (%0d,%0d): got %0d, want %0d",
                                 want.x, want.y, got_color, want.color));
            if (got_x !== want.x)
                report($sformatf("x: got %0d, want %0d", got_x, want.x));
            if (got_y !== want.y)
                report($sformatf("y: got %0d, want %0d", got_y, want.y));
            if (last !== want.last)
                report($sformatf("frame end at (%0d,%0d): got %b, want %b",
                                 want.x, want.y, last, want.last));
            if (data[M_TDATA_W-1:COLOR_W+X_W+Y_W] !== '0)
                report($sformatf("nonzero pad bits in %h", data));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CIDX_W-1:0]      cfg_index = '0;
    logic [CDATA_W-1:0]     cfg_data = '0;
    bit                     idle_on = 1'b1;
    raster_scoreboard       sb;

    text_mode_char_raster_gen_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast);
    end

    task automatic send_item(op_t op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        if (idle_on) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(S_TDATA_W-ADDR_W-DATA_W){1'b0}}, data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, addr, data);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // upper data bits are random; only bit 0 should stick
    task automatic program_regs(logic wide, logic colored);
        logic [CIDX_W-1:0]  idx [3];
        logic [CDATA_W-1:0] val [3];
        idx[0] = REG_WIDE_MODE;
        val[0] = {7'($urandom), wide};
        idx[1] = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        val[1] = CDATA_W'($urandom);
        idx[2] = REG_COLOR_ENABLE;
        val[2] = {7'($urandom), colored};
        wait_idle();
        foreach (idx[i]) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.note_config(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // mixed ticks and writes; many writes land just ahead of the beam
    task automatic run_random(int count);
        int                pick;
        op_t               op;
        logic [ADDR_W-1:0] addr;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            addr = ADDR_W'($urandom);
            if (pick < 50) op = OP_TICK;
            else if (pick < 66) op = OP_WR_VIDEO;
            else if (pick < 82) op = OP_WR_COLOR;
            else op = OP_WR_GLYPH;
            if (op == OP_WR_VIDEO || op == OP_WR_COLOR) begin
                pick = $urandom_range(0, 9);
                if (pick < 4) addr = {1'b0, sb.cell_now() + VIDEO_AW'($urandom_range(0, 3))};
                else if (pick < 8) addr[ADDR_W-1] = 1'b0;
            end else if (op == OP_WR_GLYPH && $urandom_range(0, 1)) begin
                addr = sb.glyph_now();
            end
            send_item(op, addr, DATA_W'($urandom));
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // the beam stays on the first two lines, so only the first 64 cells
        // and glyph lines 0 and 1 of each code are ever read
        for (int c = 0; c < GLYPH_CODES; c++)
            for (int l = 0; l < FILL_LINES; l++)
                send_item(OP_WR_GLYPH, ADDR_W'(c * 8 + l), DATA_W'($urandom));
        for (int a = 0; a < FILL_CELLS; a++) begin
            send_item(OP_WR_VIDEO, ADDR_W'(a), DATA_W'($urandom));
            send_item(OP_WR_COLOR, ADDR_W'(a), DATA_W'($urandom));
        end

        send_item(OP_WR_VIDEO, 11'd0, 8'hFF);
        send_item(OP_WR_GLYPH, 11'h7F8, 8'hA5);
        repeat (4) send_item(OP_TICK, '1, '1);
        send_item(OP_WR_VIDEO, 11'd1024, 8'h00);
        send_item(OP_WR_VIDEO, 11'h7FF, 8'h00);
        send_item(OP_WR_COLOR, 11'h7FF, 8'hFF);
        send_item(OP_WR_COLOR, 11'd0, 8'hFF);
        send_item(OP_WR_VIDEO, 11'd1023, 8'h00);
        send_item(OP_WR_GLYPH, 11'h7FF, 8'hFF);
        send_item(OP_WR_GLYPH, 11'h000, 8'h00);
        repeat (4) send_item(OP_TICK, '0, '0);
        send_item(OP_WR_VIDEO, 11'd1, 8'h00);
        repeat (4) send_item(OP_TICK, '1, '0);

        run_random(200);
        program_regs(1'b0, 1'b1);
        run_random(200);
        program_regs(1'b1, 1'b1);

        // a long stretch with no idling on either side
        idle_on <= 1'b0;
        run_random(200);
        idle_on <= 1'b1;

        program_regs(1'b0, 1'b0);
        run_random(190);

        wait_idle();
        $display("Covered %0d items and %0d pixels on the first scan lines,", sb.items_taken,
                 sb.pixels_checked);
        $display("both layouts with color on and off, writes near the beam and out of range.");
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d pixels still expected", sb.pending_pixels.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
